### src/npms_pkg.sv
// ----------------------------------------------------------------------------
// npms_pkg
// Types, widths and codes for the nonzero pixel mean and deviation unit.
// ----------------------------------------------------------------------------
package npms_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int COUNT_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_BITS   = 24;

	// accumulator widths: exact sums over a saturated count
	localparam int SUM_BITS   = PIXEL_BITS + COUNT_BITS;
	localparam int SQ_BITS    = 2 * (PIXEL_BITS - 1) + COUNT_BITS;

	// shared datapath widths
	localparam int WORK_BITS     = SQ_BITS + COUNT_BITS + 2 * FRAC_BITS;
	localparam int DIFF_BITS     = WORK_BITS - 2 * FRAC_BITS;
	localparam int MEAN_DIV_BITS = SUM_BITS + FRAC_BITS + 1;
	localparam int DEN_BITS      = 2 * COUNT_BITS;
	localparam int REM_BITS      = DEN_BITS;
	localparam int ROOT_BITS     = OUT_BITS;
	localparam int RADICAND_BITS = 2 * ROOT_BITS;
	localparam int STEP_BITS     = $clog2(WORK_BITS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};
	localparam logic [OUT_BITS-1:0]   MEAN_POS_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic [OUT_BITS-1:0]   MEAN_NEG_MAX = {1'b1, {(OUT_BITS-1){1'b0}}};

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_SINGLE   = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel;
		logic                         is_last;
	} sample_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] mean;
		logic [OUT_BITS-1:0]        std_dev;
		logic [OUT_BITS-1:0]        pixel_count;
		logic [1:0]                 status;
	} result_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_PREP,
		ST_MPREP,
		ST_MDIV,
		ST_MEND,
		ST_MULA,
		ST_MULB,
		ST_MULN,
		ST_SUBN,
		ST_SUB,
		ST_VDIV,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage

### src/nonzero_pixel_mean_stddev_unit.sv
// ----------------------------------------------------------------------------
// nonzero_pixel_mean_stddev_unit
// Accumulates nonzero pixels and reports mean and sample standard deviation.
// A pixel that is not last is taken every cycle. After a last pixel the
// result is computed on the shared 94-bit adder, retiring one bit a cycle;
// no pixels or overflow skip straight to the result, one pixel skips the
// deviation. Pixels stall until the result is taken into a free result slot.
// Reset clears the accumulators, the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module nonzero_pixel_mean_stddev_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  npms_pkg::sample_t  sample,
	output logic               result_valid,
	input  logic               result_stall,
	output npms_pkg::result_t  result
);

	localparam int WB = npms_pkg::WORK_BITS;
	localparam int SB = npms_pkg::STEP_BITS;

	npms_pkg::state_t state_q, state_d;

	// accumulators
	logic [npms_pkg::SUM_BITS-1:0]   acc_sum_q;
	logic [npms_pkg::SQ_BITS-1:0]    acc_sq_q;
	logic [npms_pkg::COUNT_BITS-1:0] count_q;
	logic                            ovf_q;

	// working registers
	logic [WB-1:0]                     wa_q;
	logic [WB-1:0]                     wb_q;
	logic [npms_pkg::REM_BITS-1:0]     rem_q;
	logic [npms_pkg::DEN_BITS-1:0]     den_q;
	logic [npms_pkg::ROOT_BITS-1:0]    root_q;
	logic [npms_pkg::OUT_BITS-1:0]     mean_q;
	logic                              neg_q;
	logic                              vbig_q;
	logic [SB-1:0]                     step_q;

	logic                 result_valid_q;
	npms_pkg::result_t    result_q;

	// shared adder
	logic [WB-1:0] add_x, add_y;
	logic          add_sub;
	logic [WB:0]   add_res;
	logic          add_carry;

	logic                                  accept;
	logic                                  step_done;
	logic                                  slot_free;
	logic [npms_pkg::REM_BITS:0]           div_shift;
	logic [npms_pkg::ROOT_BITS+2:0]        sq_shift;
	logic [npms_pkg::MEAN_DIV_BITS-1:0]    mean_quo;
	logic signed [2*npms_pkg::PIXEL_BITS-1:0] pix_sq;
	logic [1:0]                            status_d;

	assign accept    = sample_valid && !sample_stall;
	assign step_done = (step_q == '0);
	assign slot_free = !result_valid_q || !result_stall;
	assign div_shift = {rem_q, wa_q[WB-1]};
	assign sq_shift  = {rem_q[npms_pkg::ROOT_BITS:0],
		wa_q[npms_pkg::RADICAND_BITS-1 -: 2]};
	assign mean_quo  = wa_q[npms_pkg::MEAN_DIV_BITS-1:0];
	assign pix_sq    = sample.pixel * sample.pixel;

	assign add_res   = {1'b0, add_x} + {1'b0, add_y ^ {WB{add_sub}}} + (WB+1)'(add_sub);
	assign add_carry = add_res[WB];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npms_pkg::ST_ACCUM: begin
				if (accept && sample.is_last)
					state_d = npms_pkg::ST_PREP;
			end
			npms_pkg::ST_PREP: begin
				if (ovf_q || count_q == '0)
					state_d = npms_pkg::ST_DONE;
				else
					state_d = npms_pkg::ST_MPREP;
			end
			npms_pkg::ST_MPREP: state_d = npms_pkg::ST_MDIV;
			npms_pkg::ST_MDIV: begin
				if (step_done)
					state_d = npms_pkg::ST_MEND;
			end
			npms_pkg::ST_MEND: begin
				if (count_q == npms_pkg::COUNT_BITS'(1))
					state_d = npms_pkg::ST_DONE;
				else
					state_d = npms_pkg::ST_MULA;
			end
			npms_pkg::ST_MULA: begin
				if (step_done)
					state_d = npms_pkg::ST_MULB;
			end
			npms_pkg::ST_MULB: begin
				if (step_done)
					state_d = npms_pkg::ST_MULN;
			end
			npms_pkg::ST_MULN: begin
				if (step_done)
					state_d = npms_pkg::ST_SUBN;
			end
			npms_pkg::ST_SUBN: state_d = npms_pkg::ST_SUB;
			npms_pkg::ST_SUB: begin
				if (add_carry)
					state_d = npms_pkg::ST_VDIV;
				else
					state_d = npms_pkg::ST_DONE;
			end
			npms_pkg::ST_VDIV: begin
				if (step_done)
					state_d = npms_pkg::ST_SQRT;
			end
			npms_pkg::ST_SQRT: begin
				if (step_done)
					state_d = npms_pkg::ST_DONE;
			end
			npms_pkg::ST_DONE: begin
				if (slot_free)
					state_d = npms_pkg::ST_ACCUM;
			end
			default: state_d = npms_pkg::ST_ACCUM;
		endcase
	end

	// adder operands and handshake
	always_comb begin
		sample_stall = (state_q != npms_pkg::ST_ACCUM);
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			npms_pkg::ST_PREP: begin
				// magnitude of the sum
				add_y   = WB'(acc_sum_q);
				add_sub = 1'b1;
			end
			npms_pkg::ST_MPREP: begin
				// sum * 2^(f+1) + n, halved by the 2n divisor: rounds half away
				add_x = WB'({acc_sum_q, {(npms_pkg::FRAC_BITS+1){1'b0}}});
				add_y = WB'(count_q);
			end
			npms_pkg::ST_MDIV: begin
				add_x   = WB'(div_shift);
				add_y   = WB'({count_q, 1'b0});
				add_sub = 1'b1;
			end
			npms_pkg::ST_MULA: begin
				add_x = {wb_q[WB-2:0], 1'b0};
				add_y = count_q[step_q[4:0]] ? WB'(acc_sq_q) : '0;
			end
			npms_pkg::ST_MULB: begin
				add_x = {wa_q[WB-2:0], 1'b0};
				add_y = acc_sum_q[step_q[5:0]] ? WB'(acc_sum_q) : '0;
			end
			npms_pkg::ST_MULN: begin
				add_x = WB'({den_q[npms_pkg::DEN_BITS-2:0], 1'b0});
				add_y = count_q[step_q[4:0]] ? WB'(count_q) : '0;
			end
			npms_pkg::ST_SUBN: begin
				add_x   = WB'(den_q);
				add_y   = WB'(count_q);
				add_sub = 1'b1;
			end
			npms_pkg::ST_SUB: begin
				add_x   = wb_q;
				add_y   = wa_q;
				add_sub = 1'b1;
			end
			npms_pkg::ST_VDIV: begin
				add_x   = WB'(div_shift);
				add_y   = WB'(den_q);
				add_sub = 1'b1;
			end
			npms_pkg::ST_SQRT: begin
				add_x   = WB'(sq_shift);
				add_y   = WB'({root_q, 2'b01});
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (ovf_q)
			status_d = npms_pkg::STATUS_OVERFLOW;
		else if (count_q == '0)
			status_d = npms_pkg::STATUS_EMPTY;
		else if (count_q == npms_pkg::COUNT_BITS'(1))
			status_d = npms_pkg::STATUS_SINGLE;
		else
			status_d = npms_pkg::STATUS_OK;
	end

	// control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= npms_pkg::ST_ACCUM;
			result_valid_q <= 1'b0;
			acc_sum_q      <= '0;
			acc_sq_q       <= '0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			step_q         <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == npms_pkg::ST_DONE && slot_free)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
			case (state_q)
				npms_pkg::ST_ACCUM: begin
					if (accept && sample.pixel != '0) begin
						if (count_q == npms_pkg::COUNT_MAX) begin
							ovf_q <= 1'b1;
						end else begin
							acc_sum_q <= acc_sum_q + {{(npms_pkg::SUM_BITS-npms_pkg::PIXEL_BITS)
								{sample.pixel[npms_pkg::PIXEL_BITS-1]}}, sample.pixel};
							acc_sq_q  <= acc_sq_q + npms_pkg::SQ_BITS'($unsigned(pix_sq));
							count_q   <= count_q + npms_pkg::COUNT_BITS'(1);
						end
					end
				end
				npms_pkg::ST_PREP: begin
					// keep the magnitude in place of the signed sum
					if (acc_sum_q[npms_pkg::SUM_BITS-1])
						acc_sum_q <= add_res[npms_pkg::SUM_BITS-1:0];
				end
				npms_pkg::ST_MPREP: step_q <= SB'(npms_pkg::MEAN_DIV_BITS - 1);
				npms_pkg::ST_MEND:  step_q <= SB'(npms_pkg::COUNT_BITS - 1);
				npms_pkg::ST_MULA: begin
					if (step_done)
						step_q <= SB'(npms_pkg::SUM_BITS - 1);
					else
						step_q <= step_q - SB'(1);
				end
				npms_pkg::ST_MULB: begin
					if (step_done)
						step_q <= SB'(npms_pkg::COUNT_BITS - 1);
					else
						step_q <= step_q - SB'(1);
				end
				npms_pkg::ST_SUB:  step_q <= SB'(WB - 1);
				npms_pkg::ST_VDIV: begin
					if (step_done)
						step_q <= SB'(npms_pkg::ROOT_BITS - 1);
					else
						step_q <= step_q - SB'(1);
				end
				npms_pkg::ST_DONE: begin
					if (slot_free) begin
						acc_sum_q      <= '0;
						acc_sq_q       <= '0;
						count_q        <= '0;
						ovf_q          <= 1'b0;
					end
				end
				default: step_q <= step_q - SB'(1);
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			npms_pkg::ST_PREP: begin
				neg_q  <= acc_sum_q[npms_pkg::SUM_BITS-1];
				mean_q <= '0;
				root_q <= '0;
				vbig_q <= 1'b0;
			end
			npms_pkg::ST_MPREP: begin
				wa_q  <= {add_res[npms_pkg::MEAN_DIV_BITS-1:0],
					{(WB-npms_pkg::MEAN_DIV_BITS){1'b0}}};
				rem_q <= '0;
			end
			npms_pkg::ST_MDIV, npms_pkg::ST_VDIV: begin
				wa_q  <= {wa_q[WB-2:0], add_carry};
				if (state_q == npms_pkg::ST_VDIV && step_done) begin
					vbig_q <= |wa_q[WB-2:npms_pkg::RADICAND_BITS-1];
					rem_q  <= '0;
				end else begin
					rem_q <= add_carry ? add_res[npms_pkg::REM_BITS-1:0]
						: div_shift[npms_pkg::REM_BITS-1:0];
				end
			end
			npms_pkg::ST_MEND: begin
				if (neg_q)
					mean_q <= (mean_quo > npms_pkg::MEAN_DIV_BITS'(npms_pkg::MEAN_NEG_MAX))
						? npms_pkg::MEAN_NEG_MAX
						: ~mean_quo[npms_pkg::OUT_BITS-1:0] + npms_pkg::OUT_BITS'(1);
				else
					mean_q <= (mean_quo > npms_pkg::MEAN_DIV_BITS'(npms_pkg::MEAN_POS_MAX))
						? npms_pkg::MEAN_POS_MAX : mean_quo[npms_pkg::OUT_BITS-1:0];
				wa_q  <= '0;
				wb_q  <= '0;
				den_q <= '0;
			end
			npms_pkg::ST_MULA: wb_q <= add_res[WB-1:0];
			npms_pkg::ST_MULB: wa_q <= add_res[WB-1:0];
			npms_pkg::ST_MULN, npms_pkg::ST_SUBN: begin
				den_q <= add_res[npms_pkg::DEN_BITS-1:0];
			end
			npms_pkg::ST_SUB: begin
				// difference scaled by 4^f as the variance dividend
				wa_q  <= {add_res[npms_pkg::DIFF_BITS-1:0], {(2*npms_pkg::FRAC_BITS){1'b0}}};
				rem_q <= '0;
			end
			npms_pkg::ST_SQRT: begin
				rem_q  <= add_carry
					? npms_pkg::REM_BITS'(add_res[npms_pkg::ROOT_BITS+2:0])
					: npms_pkg::REM_BITS'(sq_shift);
				root_q <= {root_q[npms_pkg::ROOT_BITS-2:0], add_carry};
				wa_q   <= {wa_q[WB-3:0], 2'b00};
			end
			npms_pkg::ST_DONE: begin
				if (slot_free) begin
					result_q.mean        <= (ovf_q || count_q == '0) ? '0 : mean_q;
					result_q.std_dev     <= vbig_q ? npms_pkg::OUT_MAX : root_q;
					result_q.pixel_count <= npms_pkg::OUT_BITS'(count_q);
					result_q.status      <= status_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
